### rtl/core/ptsc_pkg.sv
package ptsc_pkg;

    localparam int CODE_W  = 10;
    localparam int DATA_W  = 8;
    localparam int WORD_W  = 62;
    localparam int GROUP_W = 6;
    localparam int N_GROUP = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 128;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 1;

    typedef logic [CODE_W-1:0] tmds_code_t;
    typedef logic [WORD_W-1:0] pin_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_PAIRS   = 2'd0,
        CFG_RED_HIGH_ORDER = 2'd1,
        CFG_SWAP_RED_GREEN = 2'd2
    } cfg_index_t;

    localparam logic [7:0] SYNC_IDX_0 = 8'd251;
    localparam logic [7:0] SYNC_IDX_1 = 8'd252;
    localparam logic [7:0] SYNC_IDX_2 = 8'd253;
    localparam logic [7:0] SYNC_IDX_3 = 8'd254;

    localparam tmds_code_t CTL_A = 10'b1101010100;
    localparam tmds_code_t CTL_B = 10'b0010101011;
    localparam tmds_code_t CTL_C = 10'b0101010100;
    localparam tmds_code_t CTL_D = 10'b1010101011;

    localparam pin_word_t PARTNER_MASK = 62'h0003_ffff_ffff_ffff;

    // Transition-minimising stage, no disparity balance
    function automatic tmds_code_t tmds_stage(input logic [DATA_W-1:0] d);
        logic [3:0] ones;
        logic       use_xnor;
        tmds_code_t q;
        ones = 4'd0;
        for (int k = 0; k < DATA_W; k++) begin
            ones = ones + {3'd0, d[k]};
        end
        use_xnor = (ones > 4'd4) || ((ones == 4'd4) && !d[0]);
        q = '0;
        q[0] = d[0];
        for (int k = 1; k < DATA_W; k++) begin
            q[k] = q[k-1] ^ d[k] ^ use_xnor;
        end
        q[8] = !use_xnor;
        q[9] = use_xnor;
        return q;
    endfunction

    function automatic logic [1:0] pair_of(input logic b, input logic invert);
        logic [1:0] p;
        p = {~b, b};
        if (invert) begin
            p = ~p;
        end
        return p;
    endfunction

    // Interleave three codes into pin groups, LSB first, gap after fifth group
    function automatic pin_word_t pack_word(
        input tmds_code_t red,
        input tmds_code_t green,
        input tmds_code_t blue,
        input logic       invert,
        input logic       red_high,
        input logic       swap_rg
    );
        pin_word_t  w;
        tmds_code_t r;
        tmds_code_t g;
        logic [1:0] pr;
        logic [1:0] pg;
        logic [1:0] pb;
        logic [GROUP_W-1:0] d6;
        w = '0;
        r = swap_rg ? green : red;
        g = swap_rg ? red : green;
        for (int k = 0; k < N_GROUP; k++) begin
            pr = pair_of(r[k], invert);
            pg = pair_of(g[k], invert);
            pb = pair_of(blue[k], invert);
            d6 = red_high ? {pr, pg, pb} : {pb, pg, pr};
            if (k < 5) begin
                w[GROUP_W*k +: GROUP_W] = d6;
            end else begin
                w[GROUP_W*k + 2 +: GROUP_W] = d6;
            end
        end
        return w;
    endfunction

endpackage

### rtl/core/palette_tmds_serial_converter_unit.sv
// Channel | Dir | tdata fields (low bit up)                 | tuser
// s_      | in  | color_index[7:0], color_rgb[31:8]          | -
// m_      | out | first_word[61:0], second_word[123:62], 0s | is_reserved
// cfg_    | in  | cfg_wr_en, cfg_addr (register index), cfg_wdata
//
// One word in and one word out per cycle while m_tready stays high; a word
// passes the input register, then is encoded and packed into the result register.
// Reset (aresetn, synchronous) clears both valid flags and loads the register
// defaults: invert_pairs 0, red_high_order 1, swap_red_green 0.
// A stalled result holds in the output register; the input register still
// takes a word whenever the result register can move on.
module palette_tmds_serial_converter_unit
    import ptsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // color_index[7:0], color_rgb[31:8]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // first_word[61:0], second_word[123:62], zero pad
    output logic                 m_tuser,   // is_reserved

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    logic        invert_reg;
    logic        red_high_reg;
    logic        swap_rg_reg;

    logic        in_valid_reg;
    logic [7:0]  index_reg;
    logic [23:0] rgb_reg;

    logic        out_valid_reg;
    pin_word_t   first_reg;
    pin_word_t   second_reg;
    logic        reserved_reg;

    logic        out_advance;
    logic        in_load;

    logic        is_sync;
    tmds_code_t  red_code;
    tmds_code_t  green_code;
    tmds_code_t  blue_code;
    pin_word_t   word_next;

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_load     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg   <= 1'b0;
            red_high_reg <= 1'b1;
            swap_rg_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_INVERT_PAIRS:   invert_reg   <= cfg_wdata[0];
                CFG_RED_HIGH_ORDER: red_high_reg <= cfg_wdata[0];
                CFG_SWAP_RED_GREEN: swap_rg_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            index_reg <= s_tdata[7:0];
            rgb_reg   <= s_tdata[31:8];
        end
    end

    always_comb begin
        is_sync    = 1'b1;
        red_code   = CTL_A;
        green_code = CTL_A;
        case (index_reg)
            SYNC_IDX_0: blue_code = CTL_D;
            SYNC_IDX_1: blue_code = CTL_C;
            SYNC_IDX_2: blue_code = CTL_B;
            SYNC_IDX_3: blue_code = CTL_A;
            default: begin
                is_sync    = 1'b0;
                red_code   = tmds_stage(rgb_reg[23:16]);
                green_code = tmds_stage(rgb_reg[15:8]);
                blue_code  = tmds_stage(rgb_reg[7:0]);
            end
        endcase
        word_next = pack_word(red_code, green_code, blue_code,
                              invert_reg, red_high_reg, swap_rg_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            first_reg    <= word_next;
            second_reg   <= is_sync ? word_next : (word_next ^ PARTNER_MASK);
            reserved_reg <= is_sync;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*WORD_W){1'b0}}, second_reg, first_reg};
    assign m_tuser  = reserved_reg;

endmodule

### tb/pin_word_checker.sv
`timescale 1ns / 1ps

module pin_word_checker
    import ptsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output int                   mismatch_count,
    output int                   words_pending
);

    typedef struct {
        pin_word_t first_word;
        pin_word_t second_word;
        logic      is_reserved;
    } pin_words_t;

    pin_words_t expected_pin_words[$];

    logic swap_lines;
    logic red_on_top;
    logic red_green_swapped;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic tmds_code_t minimise_transitions(input logic [7:0] d);
        int         ones;
        logic       chain_xnor;
        tmds_code_t q;
        ones = $countones(d);
        chain_xnor = (ones > 4) || (ones == 4 && !d[0]);
        q = '0;
        q[0] = d[0];
        for (int k = 1; k < 8; k++) begin
            q[k] = q[k-1] ^ d[k] ^ chain_xnor;
        end
        q[9:8] = chain_xnor ? 2'b10 : 2'b01;
        return q;
    endfunction

    function automatic pin_word_t interleave_codes(input tmds_code_t red,
                                                   input tmds_code_t green,
                                                   input tmds_code_t blue);
        pin_word_t  w;
        tmds_code_t r_code;
        tmds_code_t g_code;
        logic [1:0] r_lines;
        logic [1:0] g_lines;
        logic [1:0] b_lines;
        w = '0;
        r_code = red_green_swapped ? green : red;
        g_code = red_green_swapped ? red : green;
        for (int k = 0; k < 10; k++) begin
            // low line carries the bit, high line its complement; swap_lines inverts both
            r_lines = {~r_code[k], r_code[k]} ^ {2{swap_lines}};
            g_lines = {~g_code[k], g_code[k]} ^ {2{swap_lines}};
            b_lines = {~blue[k], blue[k]} ^ {2{swap_lines}};
            // two spare bits sit between the fifth and sixth groups
            w[(k < 5 ? 6 * k : 6 * k + 2) +: 6] =
                red_on_top ? {r_lines, g_lines, b_lines} : {b_lines, g_lines, r_lines};
        end
        return w;
    endfunction

    function automatic pin_words_t predict_pin_words(input logic [7:0] index,
                                                     input logic [23:0] rgb);
        pin_words_t res;
        tmds_code_t blue_ctl;
        if (index >= SYNC_IDX_0 && index <= SYNC_IDX_3) begin
            case (index)
                SYNC_IDX_0: blue_ctl = CTL_D;
                SYNC_IDX_1: blue_ctl = CTL_C;
                SYNC_IDX_2: blue_ctl = CTL_B;
                default:    blue_ctl = CTL_A;
            endcase
            res.first_word  = interleave_codes(CTL_A, CTL_A, blue_ctl);
            res.second_word = res.first_word;
            res.is_reserved = 1'b1;
        end else begin
            res.first_word  = interleave_codes(minimise_transitions(rgb[23:16]),
                                               minimise_transitions(rgb[15:8]),
                                               minimise_transitions(rgb[7:0]));
            res.second_word = res.first_word ^ PARTNER_MASK;
            res.is_reserved = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        pin_words_t want;
        if (!aresetn) begin
            swap_lines        <= 1'b0;
            red_on_top        <= 1'b1;
            red_green_swapped <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_INVERT_PAIRS:   swap_lines        <= cfg_wdata[0];
                    CFG_RED_HIGH_ORDER: red_on_top        <= cfg_wdata[0];
                    CFG_SWAP_RED_GREEN: red_green_swapped <= cfg_wdata[0];
                    default: ;
                endcase
            end
            // retire the oldest word before queueing a new one
            if (m_tvalid && m_tready) begin
                if (expected_pin_words.size() == 0) begin
                    report_mismatch("result word with nothing expected",
                                    m_tdata[63:0], '0);
                end else begin
                    want = expected_pin_words.pop_front();
                    if (m_tdata[61:0] !== want.first_word) begin
                        report_mismatch("first_word", 64'(m_tdata[61:0]),
                                        64'(want.first_word));
                    end
                    if (m_tdata[123:62] !== want.second_word) begin
                        report_mismatch("second_word", 64'(m_tdata[123:62]),
                                        64'(want.second_word));
                    end
                    if (m_tuser !== want.is_reserved) begin
                        report_mismatch("is_reserved", 64'(m_tuser),
                                        64'(want.is_reserved));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pin_words.push_back(predict_pin_words(s_tdata[7:0], s_tdata[31:8]));
            end
        end
        words_pending <= expected_pin_words.size();
    end

endmodule

### tb/palette_tmds_serial_converter_unit_test.sv
`timescale 1ns / 1ps

module palette_tmds_serial_converter_unit_test;
    import ptsc_pkg::*;

    localparam int QUIET_LIMIT      = 4000;
    localparam int WORDS_PER_PHASE  = 144;
    localparam int SEND_IDLE_PCT[4]  = '{0, 61, 0, 36};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 61, 36};
    localparam logic [7:0] CHANNEL_CORNERS[6] = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h55, 8'haa};
    // {rgb, index}: channel extremes, popcount ties, every sync entry, 250 and 255
    localparam logic [31:0] DIRECTED_WORDS[18] = '{
        32'h000000_00, 32'hffffff_00, 32'hffffff_ff, 32'h000000_ff,
        32'h0f0f0f_fa, 32'hf0f0f0_01, 32'h1ff807_02, 32'h7ffe01_80,
        32'haa5501_7f, 32'h3cc317_40, 32'he0ff01_c0, 32'hffffff_fb,
        32'h000000_fc, 32'h123456_fd, 32'h5a5a5a_fe, 32'h000000_fa,
        32'hffffff_fe, 32'h8001ff_fb
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    int mismatch_count;
    int words_pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    palette_tmds_serial_converter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pin_word_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("palette_tmds_serial_converter_unit verification failed");
            $finish;
        end
    end

    task automatic push_colour(input logic [7:0] index, input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rgb, index};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // drop valid, then hold until every word has come back
    task automatic drain_words();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (words_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_registers(input logic swap_lines, input logic red_on_top,
                                  input logic swap_rg);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_INVERT_PAIRS;
        cfg_wdata <= swap_lines;
        @(posedge aclk);
        cfg_addr  <= CFG_RED_HIGH_ORDER;
        cfg_wdata <= red_on_top;
        @(posedge aclk);
        cfg_addr  <= CFG_SWAP_RED_GREEN;
        cfg_wdata <= swap_rg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [7:0]  index;
        logic [23:0] rgb;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_INVERT_PAIRS;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults stay in force for the directed words
        foreach (DIRECTED_WORDS[i]) begin
            push_colour(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][31:8]);
        end

        for (int phase = 0; phase < 8; phase++) begin
            drain_words();
            load_registers(phase[0], !phase[1], phase[2]);
            send_idle_pct  = SEND_IDLE_PCT[phase % 4];
            recv_stall_pct = RECV_STALL_PCT[phase % 4];
            repeat (WORDS_PER_PHASE) begin
                case ($urandom_range(9))
                    0, 1:    index = 8'($urandom_range(SYNC_IDX_3, SYNC_IDX_0));
                    2:       index = 8'($urandom_range(255, 248));
                    default: index = 8'($urandom_range(255));
                endcase
                for (int c = 0; c < 3; c++) begin
                    rgb[8*c +: 8] = ($urandom_range(3) == 0) ?
                                    CHANNEL_CORNERS[$urandom_range(5)] :
                                    8'($urandom_range(255));
                end
                push_colour(index, rgb);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_words();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && words_pending == 0) begin
            $display("palette_tmds_serial_converter_unit verification clean");
        end else begin
            $display("palette_tmds_serial_converter_unit verification failed");
        end
        $finish;
    end

endmodule

### palette_tmds_serial_converter_unit.f
rtl/core/ptsc_pkg.sv
rtl/core/palette_tmds_serial_converter_unit.sv
tb/pin_word_checker.sv
tb/palette_tmds_serial_converter_unit_test.sv
